### rtl/bsa_pkg.sv
// Shared types and constants for the bitmap slot allocator.
// Holds field widths, register indexes, action and status codes, sequencer states and a flag struct.
// No dependencies.
`default_nettype none

package bsa_pkg;

    localparam int MAX_SLOTS_DEF = 1024;
    localparam int WORD_BITS_DEF = 64;

    localparam int SLOT_COUNT_W = 11;
    localparam int SLOT_SIZE_W  = 28;
    localparam int CFG_DATA_W   = 28;
    localparam int CFG_IDX_W    = 1;
    localparam int INDEX_W      = 32;
    localparam int SLOT_W       = 10;
    localparam int OFFSET_W     = 32;
    localparam int COUNT_W      = 11;
    localparam int TOTAL_W      = 32;

    localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RESET = 11'd1024;
    localparam logic [SLOT_SIZE_W-1:0]  SLOT_SIZE_RESET  = 28'd4194304;

    localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_SIZE  = 1'b1;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_RANGE   = 2'd2,
        ST_DOUBLE  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_MUL,
        S_FIN
    } state_t;

    typedef struct packed {
        logic avail;
        logic taken;
    } word_flags_t;

endpackage

`default_nettype wire

### rtl/bitmap_slot_allocator_core.sv
// Top level of the first-fit bitmap slot allocator: sequencer, state and result register.
// Depends on bsa_pkg, bsa_ram and bsa_word_unit.
//
//   Channel   Signals                                  Direction  Beat when
//   config    cfg_we, cfg_index, cfg_data              in         cfg_we high
//   request   in_valid/in_ready, action, slot_index    in         in_valid & in_ready
//   result    out_valid/out_ready, status .. frees     out        out_valid & out_ready
//
// After reset a clearing pass writes the bitmap to zero, one word per cycle, over all
// ceil(MAX_SLOTS / WORD_BITS) words (16 by default); requests wait, config writes do not.
// An allocate runs S_READ and S_EVAL for each word, read through the single RAM port and tested
// by the shared word unit, then S_MUL and S_FIN on a hit or S_FIN alone when none is free.
// A free runs S_READ, S_EVAL, S_MUL and S_FIN, a double free skips S_MUL, and an index out of
// range goes straight to S_FIN; word and bit are the upper and lower bits of slot_index. One
// request is in flight at a time. The result sits in an output register, so the next request is taken while it waits.
`default_nettype none

module bitmap_slot_allocator_core #(
    parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF,
    parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            action,
    input  logic [bsa_pkg::INDEX_W-1:0]     slot_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    output logic [bsa_pkg::SLOT_W-1:0]      slot,
    output logic [bsa_pkg::OFFSET_W-1:0]    byte_offset,
    output logic [bsa_pkg::COUNT_W-1:0]     used_count,
    output logic [bsa_pkg::COUNT_W-1:0]     free_count_now,
    output logic [bsa_pkg::TOTAL_W-1:0]     allocations_total,
    output logic [bsa_pkg::TOTAL_W-1:0]     frees_total
);

    import bsa_pkg::*;

    localparam int MAP_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIW       = $clog2(WORD_BITS);
    localparam int SW        = $clog2(MAX_SLOTS);
    localparam int UW        = $clog2(MAX_SLOTS + 1);
    localparam int SPAN      = $clog2(MAP_WORDS * WORD_BITS + WORD_BITS + 1);
    localparam int XW        = (SPAN > SLOT_COUNT_W) ? SPAN : SLOT_COUNT_W;

    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
    localparam logic [XW-1:0] WORD_STEP = XW'(WORD_BITS);
    localparam logic [XW-1:0] CAP       = XW'(MAX_SLOTS);

    state_t                  state_reg, state_next;
    logic [SLOT_COUNT_W-1:0] slot_count_reg;
    logic [SLOT_SIZE_W-1:0]  slot_size_reg;
    logic [AW-1:0]           w_reg, w_next;
    logic [UW-1:0]           used_reg, used_next;
    logic [TOTAL_W-1:0]      alloc_cnt_reg, alloc_cnt_next;
    logic [TOTAL_W-1:0]      rel_cnt_reg, rel_cnt_next;
    logic                    out_valid_reg, out_valid_next;

    logic                    action_reg, action_next;
    logic [XW-1:0]           base_reg, base_next;
    logic [BIW-1:0]          rem_reg, rem_next;
    logic [SW-1:0]           slot_reg, slot_next;
    status_t                 status_reg, status_next;
    logic [SLOT_SIZE_W-1:0]  prod_reg, prod_next;

    status_t                 out_status_reg, out_status_next;
    logic [SLOT_W-1:0]       out_slot_reg, out_slot_next;
    logic [OFFSET_W-1:0]     out_offset_reg, out_offset_next;
    logic [COUNT_W-1:0]      out_used_reg, out_used_next;
    logic [COUNT_W-1:0]      out_free_reg, out_free_next;
    logic [TOTAL_W-1:0]      out_alloc_reg, out_alloc_next;
    logic [TOTAL_W-1:0]      out_rel_reg, out_rel_next;

    logic [XW-1:0]           eff;
    logic [XW-1:0]           span;
    logic [XW-1:0]           base_step;
    logic [XW-1:0]           used_ext;
    logic                    ram_we;
    logic [WORD_BITS-1:0]    ram_wdata;
    logic [WORD_BITS-1:0]    ram_rdata;
    word_flags_t             flags;
    logic [BIW-1:0]          first_bit;
    logic [WORD_BITS-1:0]    set_word;
    logic [WORD_BITS-1:0]    clr_word;

    assign eff       = (XW'(slot_count_reg) > CAP) ? CAP : XW'(slot_count_reg);
    assign span      = eff - base_reg;
    assign base_step = base_reg + WORD_STEP;
    assign used_ext  = XW'(used_reg);

    bsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (w_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    bsa_word_unit #(
        .WORD_BITS (WORD_BITS),
        .SPAN_W    (XW)
    ) u_word (
        .word      (ram_rdata),
        .span      (span),
        .bit_sel   (rem_reg),
        .flags     (flags),
        .first_bit (first_bit),
        .set_word  (set_word),
        .clr_word  (clr_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            slot_count_reg <= SLOT_COUNT_RESET;
            slot_size_reg  <= SLOT_SIZE_RESET;
            w_reg          <= '0;
            used_reg       <= '0;
            alloc_cnt_reg  <= '0;
            rel_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            w_reg         <= w_next;
            used_reg      <= used_next;
            alloc_cnt_reg <= alloc_cnt_next;
            rel_cnt_reg   <= rel_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SLOT_COUNT: slot_count_reg <= cfg_data[SLOT_COUNT_W-1:0];
                    REG_SLOT_SIZE:  slot_size_reg  <= cfg_data[SLOT_SIZE_W-1:0];
                    default:        slot_count_reg <= slot_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        base_reg       <= base_next;
        rem_reg        <= rem_next;
        slot_reg       <= slot_next;
        status_reg     <= status_next;
        prod_reg       <= prod_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_offset_reg <= out_offset_next;
        out_used_reg   <= out_used_next;
        out_free_reg   <= out_free_next;
        out_alloc_reg  <= out_alloc_next;
        out_rel_reg    <= out_rel_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        w_next          = w_reg;
        used_next       = used_reg;
        alloc_cnt_next  = alloc_cnt_reg;
        rel_cnt_next    = rel_cnt_reg;
        out_valid_next  = out_valid_reg;
        action_next     = action_reg;
        base_next       = base_reg;
        rem_next        = rem_reg;
        slot_next       = slot_reg;
        status_next     = status_reg;
        prod_next       = prod_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_offset_next = out_offset_reg;
        out_used_next   = out_used_reg;
        out_free_next   = out_free_reg;
        out_alloc_next  = out_alloc_reg;
        out_rel_next    = out_rel_reg;
        ram_we          = 1'b0;
        ram_wdata       = set_word;
        in_ready        = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (w_reg == LAST_WORD)
                begin
                    w_next     = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    w_next = w_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    action_next = action;
                    w_next      = '0;
                    base_next   = '0;
                    slot_next   = '0;
                    if (action == ACT_FREE)
                    begin
                        if (slot_index >= INDEX_W'(eff))
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            rem_next   = slot_index[BIW-1:0];
                            w_next     = AW'(slot_index >> BIW);
                            slot_next  = SW'(slot_index);
                            state_next = S_READ;
                        end
                    end
                    else if (eff == '0)
                    begin
                        status_next = ST_NO_FREE;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (action_reg == ACT_ALLOC)
                begin
                    if (flags.avail)
                    begin
                        ram_we         = 1'b1;
                        ram_wdata      = set_word;
                        slot_next      = SW'(base_reg) + SW'(first_bit);
                        used_next      = used_reg + UW'(1);
                        alloc_cnt_next = alloc_cnt_reg + TOTAL_W'(1);
                        status_next    = ST_OK;
                        state_next     = S_MUL;
                    end
                    else if ((w_reg == LAST_WORD) || (base_step >= eff))
                    begin
                        status_next = ST_NO_FREE;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        w_next     = w_reg + AW'(1);
                        base_next  = base_step;
                        state_next = S_READ;
                    end
                end
                else if (!flags.taken)
                begin
                    slot_next   = '0;
                    status_next = ST_DOUBLE;
                    state_next  = S_FIN;
                end
                else
                begin
                    ram_we       = 1'b1;
                    ram_wdata    = clr_word;
                    if (used_reg != '0)
                    begin
                        used_next = used_reg - UW'(1);
                    end
                    rel_cnt_next = rel_cnt_reg + TOTAL_W'(1);
                    status_next  = ST_OK;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = SLOT_SIZE_W'(slot_reg * slot_size_reg);
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_slot_next   = (status_reg == ST_OK) ? SLOT_W'(slot_reg) : '0;
                    out_offset_next = (status_reg == ST_OK) ? {prod_reg, 4'b0000} : '0;
                    out_used_next   = COUNT_W'(used_reg);
                    out_free_next   = (eff > used_ext) ? COUNT_W'(eff - used_ext) : '0;
                    out_alloc_next  = alloc_cnt_reg;
                    out_rel_next    = rel_cnt_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign out_valid         = out_valid_reg;
    assign status            = out_status_reg;
    assign slot              = out_slot_reg;
    assign byte_offset       = out_offset_reg;
    assign used_count        = out_used_reg;
    assign free_count_now    = out_free_reg;
    assign allocations_total = out_alloc_reg;
    assign frees_total       = out_rel_reg;

    a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(MAX_SLOTS))
        else $error("Used slot count exceeds the pool capacity.");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("A second request beat was taken while one is in flight.");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("Bitmap written while the sequencer is idle.");

    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(alloc_cnt_reg) |-> (alloc_cnt_reg == $past(alloc_cnt_reg) + 32'd1))
        else $error("Allocation counter moved by other than one.");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_valid_reg && !out_ready) |=> (state_reg == S_FIN))
        else $error("Result overwritten before the previous beat was taken.");

endmodule

`default_nettype wire

### rtl/bsa_ram.sv
// Generic single-port RAM with registered read data.
// Used for the slot bitmap; no dependencies.
`default_nettype none

module bsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[addr] <= wdata;
        end
        rdata_reg <= ram_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/bsa_word_unit.sv
// Shared evaluation unit for one bitmap word: free-bit search below the slot limit,
// single-bit test, and the set and clear forms of the word. Depends on bsa_pkg.
`default_nettype none

module bsa_word_unit #(
    parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF,
    parameter int SPAN_W    = 11,
    localparam int BIW = $clog2(WORD_BITS)
) (
    input  logic [WORD_BITS-1:0] word,
    input  logic [SPAN_W-1:0]    span,
    input  logic [BIW-1:0]       bit_sel,
    output bsa_pkg::word_flags_t flags,
    output logic [BIW-1:0]       first_bit,
    output logic [WORD_BITS-1:0] set_word,
    output logic [WORD_BITS-1:0] clr_word
);

    import bsa_pkg::*;

    logic [WORD_BITS-1:0] avail;

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            avail[b] = ~word[b] & (SPAN_W'(b) < span);
        end
    end

    always_comb
    begin
        first_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                first_bit = BIW'(b);
            end
        end
    end

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            set_word[b] = word[b] | (BIW'(b) == first_bit);
            clr_word[b] = word[b] & (BIW'(b) != bit_sel);
        end
    end

    assign flags.avail = |avail;
    assign flags.taken = word[bit_sel];

endmodule

`default_nettype wire

### tb/sv/tb_bitmap_slot_allocator_core.sv
// Self-checking testbench for bitmap_slot_allocator_core: first-fit allocate and free
// requests against a bit-level slot pool predictor, with random stalls on both channels.
// Depends on bsa_pkg and bitmap_slot_allocator_core.
`default_nettype none

module tb_bitmap_slot_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bsa_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;

    typedef struct {
        logic [1:0]          status;
        logic [SLOT_W-1:0]   slot;
        logic [OFFSET_W-1:0] byte_offset;
        logic [COUNT_W-1:0]  used;
        logic [COUNT_W-1:0]  free_left;
        logic [TOTAL_W-1:0]  allocs;
        logic [TOTAL_W-1:0]  frees;
    } alloc_result_t;

    class slot_pool_scoreboard;
        bit [MAX_SLOTS_DEF-1:0]  held;
        logic [COUNT_W-1:0]      used_slots;
        logic [TOTAL_W-1:0]      alloc_total;
        logic [TOTAL_W-1:0]      free_total;
        logic [SLOT_COUNT_W-1:0] slot_count;
        logic [SLOT_SIZE_W-1:0]  unit_size;
        alloc_result_t           expected_q[$];
        int                      errors;
        int                      tally[4];

        function new();
            held        = '0;
            used_slots  = '0;
            alloc_total = '0;
            free_total  = '0;
            slot_count  = SLOT_COUNT_RESET;
            unit_size   = SLOT_SIZE_RESET;
            errors      = 0;
            foreach (tally[k]) tally[k] = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_SLOT_COUNT)
                slot_count = data[SLOT_COUNT_W-1:0];
            else
                unit_size = data[SLOT_SIZE_W-1:0];
        endfunction

        function int unsigned live_count();
            return (slot_count > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : slot_count;
        endfunction

        function int free_below(int unsigned cnt);
            int n;
            n = 0;
            for (int s = 0; s < cnt; s++) if (!held[s]) n++;
            return n;
        endfunction

        function int held_below(int unsigned cnt);
            return cnt - free_below(cnt);
        endfunction

        function int unsigned pick_held(int unsigned cnt);
            int unsigned start;
            int unsigned s;
            start = $urandom_range(cnt - 1);
            for (int unsigned i = 0; i < cnt; i++) begin
                s = (start + i) % cnt;
                if (held[s]) return s;
            end
            return start;
        endfunction

        function void note_request(logic act, logic [INDEX_W-1:0] idx);
            int unsigned   cnt;
            int unsigned   s;
            alloc_result_t r;
            logic [63:0]   prod;
            cnt           = live_count();
            r.status      = ST_NO_FREE;
            r.slot        = '0;
            r.byte_offset = '0;
            if (act == ACT_ALLOC) begin
                for (s = 0; s < cnt; s++) if (!held[s]) break;
                if (s < cnt) begin
                    held[s] = 1'b1;
                    used_slots++;
                    alloc_total++;
                    r.status = ST_OK;
                    r.slot   = s[SLOT_W-1:0];
                end
            end else if (idx >= cnt) begin
                r.status = ST_RANGE;
            end else if (!held[idx[SLOT_W-1:0]]) begin
                r.status = ST_DOUBLE;
            end else begin
                held[idx[SLOT_W-1:0]] = 1'b0;
                if (used_slots != 0) used_slots--;
                free_total++;
                r.status = ST_OK;
                r.slot   = idx[SLOT_W-1:0];
            end
            if (r.status == ST_OK) begin
                prod          = 64'(r.slot) * 64'(unit_size);
                r.byte_offset = {prod[27:0], 4'b0000};
            end
            r.used      = used_slots;
            r.free_left = (cnt > used_slots) ? COUNT_W'(cnt - used_slots) : '0;
            r.allocs    = alloc_total;
            r.frees     = free_total;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(alloc_result_t got);
            alloc_result_t exp_r;
            if (expected_q.size() == 0) begin
                $error("result beat with no request outstanding");
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            tally[exp_r.status]++;
            compare_field("status", 32'(exp_r.status), 32'(got.status));
            compare_field("slot", 32'(exp_r.slot), 32'(got.slot));
            compare_field("byte_offset", exp_r.byte_offset, got.byte_offset);
            compare_field("used_count", 32'(exp_r.used), 32'(got.used));
            compare_field("free_count_now", 32'(exp_r.free_left), 32'(got.free_left));
            compare_field("allocations_total", exp_r.allocs, got.allocs);
            compare_field("frees_total", exp_r.frees, got.frees);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;
    logic                   in_valid   = 1'b0;
    logic                   in_ready;
    logic                   action     = 1'b0;
    logic [INDEX_W-1:0]     slot_index = '0;
    logic                   out_valid;
    logic                   out_ready  = 1'b0;
    logic [1:0]             status;
    logic [SLOT_W-1:0]      slot;
    logic [OFFSET_W-1:0]    byte_offset;
    logic [COUNT_W-1:0]     used_count;
    logic [COUNT_W-1:0]     free_count_now;
    logic [TOTAL_W-1:0]     allocations_total;
    logic [TOTAL_W-1:0]     frees_total;

    slot_pool_scoreboard sb;
    int  send_idle_pct = 15;
    int  recv_idle_pct = 45;
    bit  hold_req      = 1'b0;
    int  hold_left     = 0;
    int  quiet_cycles  = 0;

    bitmap_slot_allocator_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .action            (action),
        .slot_index        (slot_index),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .slot              (slot),
        .byte_offset       (byte_offset),
        .used_count        (used_count),
        .free_count_now    (free_count_now),
        .allocations_total (allocations_total),
        .frees_total       (frees_total)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        alloc_result_t got;
        if (rst_n && out_valid && out_ready) begin
            got.status      = status;
            got.slot        = slot;
            got.byte_offset = byte_offset;
            got.used        = used_count;
            got.free_left   = free_count_now;
            got.allocs      = allocations_total;
            got.frees       = frees_total;
            sb.check_result(got);
        end
    end

    initial begin
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no beat on either channel for %0d cycles", quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_item(input logic act, input logic [INDEX_W-1:0] idx);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        slot_index <= idx;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(act, idx);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_config(input logic [SLOT_COUNT_W-1:0] cnt,
                                input logic [SLOT_SIZE_W-1:0] size);
        logic [CFG_DATA_W-1:0] data;
        data      = {17'($urandom), cnt};
        cfg_we    <= 1'b1;
        cfg_index <= REG_SLOT_COUNT;
        cfg_data  <= data;
        sb.set_register(REG_SLOT_COUNT, data);
        @(negedge clk);
        cfg_index <= REG_SLOT_SIZE;
        cfg_data  <= size;
        sb.set_register(REG_SLOT_SIZE, size);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [INDEX_W-1:0] choose_free_index(int unsigned cnt);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return (cnt != 0) ? sb.pick_held(cnt) : $urandom();
        else if (pick < 75)
            return (cnt != 0) ? $urandom_range(cnt - 1) : 0;
        else if (pick < 85)
            return cnt + $urandom_range(2) - 1;
        else if (pick < 90)
            return $urandom_range(MAX_SLOTS_DEF - 1);
        else
            return $urandom();
    endfunction

    task automatic run_phase(input logic [SLOT_COUNT_W-1:0] cnt_raw,
                             input logic [SLOT_SIZE_W-1:0] size,
                             input int n, input bit pressure, input bit mid_drain);
        int unsigned eff;
        bit          filling;
        logic        act;
        drain();
        write_config(cnt_raw, size);
        eff     = (cnt_raw > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : cnt_raw;
        filling = 1'b1;
        for (int i = 0; i < n; i++) begin
            if (pressure && i == n / 2) hold_req = 1'b1;
            if (mid_drain && i == n / 2) drain();
            if (eff != 0) begin
                if (filling && sb.free_below(eff) == 0 && $urandom_range(3) == 0)
                    filling = 1'b0;
                else if (!filling && sb.held_below(eff) == 0)
                    filling = 1'b1;
            end
            act = ($urandom_range(99) < (filling ? 80 : 20)) ? ACT_ALLOC : ACT_FREE;
            send_item(act, (act == ACT_FREE) ? choose_free_index(eff) : $urandom());
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Small pool at the largest slot size: fill, run dry, double free and range errors.
        write_config(11'd3, 28'hFFFFFFF);
        repeat (4) send_item(ACT_ALLOC, $urandom());
        send_item(ACT_FREE, 32'd1);
        send_item(ACT_FREE, 32'd1);
        send_item(ACT_FREE, 32'd3);
        send_item(ACT_FREE, 32'hFFFFFFFF);
        send_item(ACT_ALLOC, 32'hFFFFFFFF);

        // Count lowered below held slots: those above it stay counted and cannot be freed.
        drain();
        write_config(11'd1, 28'd1);
        send_item(ACT_ALLOC, 32'd0);
        send_item(ACT_FREE, 32'd2);
        send_item(ACT_FREE, 32'd0);
        send_item(ACT_ALLOC, 32'd0);

        // An empty pool rejects everything.
        drain();
        write_config(11'd0, 28'd0);
        send_item(ACT_ALLOC, 32'd0);
        send_item(ACT_FREE, 32'd0);

        // Count above capacity saturates; zero slot size gives zero offsets.
        drain();
        write_config(11'd2047, 28'd0);
        send_item(ACT_ALLOC, 32'd0);
        send_item(ACT_FREE, 32'd2);
        send_item(ACT_FREE, 32'd1023);
        send_item(ACT_FREE, 32'd1024);
        send_item(ACT_FREE, 32'h80000000);

        drain();
        write_config(11'd1024, SLOT_SIZE_RESET);
        send_item(ACT_FREE, 32'd0);
        send_item(ACT_FREE, 32'd1);
        send_item(ACT_FREE, 32'd3);
        send_item(ACT_ALLOC, 32'd0);

        send_idle_pct = 15;
        recv_idle_pct = 45;
        run_phase(11'd37, 28'($urandom_range(1, 28'hFFFFFFF)), 100, 1'b0, 1'b0);
        run_phase(11'd1, 28'd1, 60, 1'b1, 1'b0);
        run_phase(11'd130, 28'hFFFFFFF, 130, 1'b0, 1'b0);

        send_idle_pct = 45;
        recv_idle_pct = 15;
        run_phase(11'd2047, 28'($urandom()), 150, 1'b0, 1'b0);
        run_phase(11'd0, 28'($urandom()), 40, 1'b0, 1'b1);
        run_phase(11'd64, 28'd0, 100, 1'b0, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(11'd1000, 28'($urandom()), 200, 1'b0, 1'b0);
        run_phase(11'd65, 28'd1, 120, 1'b0, 1'b0);
        run_phase(11'd5, 28'($urandom_range(1, 28'hFFFFFFF)), 60, 1'b0, 1'b0);

        drain();
        repeat (40) @(negedge clk);
        $display("Checked %0d results: %0d ok, %0d pool empty, %0d out of range, %0d double free.",
                 sb.tally[ST_OK] + sb.tally[ST_NO_FREE] + sb.tally[ST_RANGE] + sb.tally[ST_DOUBLE],
                 sb.tally[ST_OK], sb.tally[ST_NO_FREE], sb.tally[ST_RANGE], sb.tally[ST_DOUBLE]);
        $display("Slot counts from 0 to 2047 and slot sizes from 0 to the maximum were exercised.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/bsa_pkg.sv
rtl/bsa_ram.sv
rtl/bsa_word_unit.sv
rtl/bitmap_slot_allocator_core.sv
tb/sv/tb_bitmap_slot_allocator_core.sv
